// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/vdec_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdec_pkg
// Types and constants of the LEB128 varint decoder.
// ---------------------------------------------------------------------------
package vdec_pkg;

  localparam int ValueW    = 64;
  localparam int ByteW     = 8;
  localparam int PosW      = 7;
  localparam int ModeW     = 2;
  localparam int StatusW   = 2;
  localparam int OutTdataW = 72;

  localparam logic [ByteW-1:0] PAYLOAD_MASK = 8'h7f;
  localparam logic [ByteW-1:0] CONT_FLAG    = 8'h80;
  localparam logic [PosW-1:0]  GROUP_BITS   = 7'd7;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NONCANON = 2'd2
  } status_t;

  typedef enum logic [ModeW-1:0] {
    MODE_W8  = 2'd0,
    MODE_W16 = 2'd1,
    MODE_W32 = 2'd2,
    MODE_W64 = 2'd3
  } width_mode_t;

  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] value;
    status_t           status;
  } step_res_t;

  function automatic logic [PosW-1:0] width_bits(input width_mode_t mode);
    logic [PosW-1:0] w;
    case (mode)
      MODE_W8:  w = 7'd8;
      MODE_W16: w = 7'd16;
      MODE_W32: w = 7'd32;
      MODE_W64: w = 7'd64;
      default:  w = 7'd64;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/vdec_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdec_step
// Combinational decode of one byte against the running accumulator.
// ---------------------------------------------------------------------------
module vdec_step
  import vdec_pkg::*;
(
  input  logic [ByteW-1:0]  data_byte,
  input  logic [ValueW-1:0] acc,
  input  logic [PosW-1:0]   pos,
  input  width_mode_t       mode,
  output logic [ValueW-1:0] acc_nxt,
  output logic [PosW-1:0]   pos_nxt,
  output step_res_t         res
);

  logic [PosW-1:0]   w;
  logic [PosW-1:0]   rem;
  logic              too_far;
  logic              near_top;
  logic              too_big;
  logic              ovf;
  logic [ValueW-1:0] acc_or;
  logic [ValueW-1:0] wmask;

  always_comb begin
    w        = width_bits(mode);
    rem      = w - pos;
    too_far  = (pos >= w);
    near_top = ((pos + GROUP_BITS) >= w);
    too_big  = near_top && ((data_byte >> rem) != '0);
    ovf      = too_far || too_big;
    acc_or   = acc | (ValueW'(data_byte & PAYLOAD_MASK) << pos);
    wmask    = (mode == MODE_W64) ? '1 : ((ValueW'(1) << w) - ValueW'(1));
  end

  always_comb begin
    acc_nxt    = '0;
    pos_nxt    = '0;
    res.emit   = 1'b1;
    res.value  = '0;
    res.status = ST_OK;
    if (ovf) begin
      res.status = ST_OVERFLOW;
    end else if ((data_byte & CONT_FLAG) != '0) begin
      // more bytes follow: keep the partial value
      acc_nxt  = acc_or;
      pos_nxt  = pos + GROUP_BITS;
      res.emit = 1'b0;
    end else if ((data_byte == '0) && (pos != '0)) begin
      res.status = ST_NONCANON;
    end else begin
      res.value = acc_or & wmask;
    end
  end

endmodule

// ===== hdl/varint_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// varint_decoder
// Unsigned LEB128 varint decoder with selectable target width.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one encoded byte per item in in_tdata[7:0]; bit 7 set means more
//           bytes of the same value follow.
//   out_* : one item per finished value or error. out_tdata[63:0] carries the
//           value (zero on error), out_tdata[65:64] the status: ok, overflow
//           for the width, or non-canonical zero final byte.
//   cfg_* : cfg_wr_en writes cfg_wr_data into the width mode (8/16/32/64
//           bits); write it only while no value is in flight.
// Timing: a byte is held in the input register and decoded into the output
//   register, which holds the result once its last byte is accepted. The
//   block takes one byte per cycle unless a final byte meets a full output
//   register; the only loop is the accumulator and bit position update.
// Reset clears the accumulator, the bit position, both valid flags, and sets
//   the width to 64 bits. When the receiver stalls, the result holds in the
//   output register; continuation bytes still drain, and the input stalls
//   only once a byte that ends a value meets a full output register.
// ---------------------------------------------------------------------------
module varint_decoder
  import vdec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [ModeW-1:0]     cfg_wr_data,     // width_mode
  // byte stream in
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ByteW-1:0]     in_tdata,        // [7:0] data_byte
  // decoded values out
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutTdataW-1:0] out_tdata        // [63:0] decoded_value,
                                                // [65:64] status, rest zero
);

  logic              in_valid_r;
  logic [ByteW-1:0]  in_byte_r;
  logic [ValueW-1:0] acc_r;
  logic [ValueW-1:0] acc_nxt;
  logic [PosW-1:0]   pos_r;
  logic [PosW-1:0]   pos_nxt;
  width_mode_t       mode_r;
  logic              out_valid_r;
  logic [ValueW-1:0] out_value_r;
  status_t           out_status_r;
  step_res_t         res;
  logic              out_free;
  logic              advance;

  vdec_step u_step (
    .data_byte (in_byte_r),
    .acc       (acc_r),
    .pos       (pos_r),
    .mode      (mode_r),
    .acc_nxt   (acc_nxt),
    .pos_nxt   (pos_nxt),
    .res       (res)
  );

  // Output register frees up when empty or when its item is taken now.
  assign out_free  = !out_valid_r || out_tready;
  // Decode the held byte unless it ends a value and the output is blocked.
  assign advance   = in_valid_r && (!res.emit || out_free);
  assign in_tready = !in_valid_r || advance;

  // Width mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_W64;
    end else if (cfg_wr_en) begin
      mode_r <= width_mode_t'(cfg_wr_data);
    end
  end

  // Input register: hold the byte until it is decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Running value state: advance once per decoded byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
    end else if (advance) begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutTdataW - ValueW - StatusW)'(0), out_status_r, out_value_r};

endmodule

// ===== hdl/vdec_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdec_checker
// Port-level checks of the varint decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vdec_checker
  import vdec_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_wr_en,
  input logic [ModeW-1:0]     cfg_wr_data,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OutTdataW-1:0] out_tdata
);

  logic [ModeW-1:0] mode_r;
  logic [1:0]       st;

  // Shadow the width mode as seen on the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_W64;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  assign st = out_tdata[65:64];

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata))
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_tvalid,
               st == ST_OK || st == ST_OVERFLOW || st == ST_NONCANON)
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_tvalid && st != ST_OK,
               out_tdata[63:0] == '0)
  `ASSERT_IMPL(a_w8_fits, clk, rst_n, out_tvalid && mode_r == MODE_W8,
               out_tdata[63:8] == '0)

endmodule

bind varint_decoder vdec_checker u_vdec_checker (.*);

// ===== verif/varint_decoder_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// varint_decoder_checker
// Watches the byte, result and width ports of the varint decoder, predicts
// every decoded value or error, and compares results field by field.
// ---------------------------------------------------------------------------
module varint_decoder_checker
  import vdec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [ModeW-1:0]     cfg_wr_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [ByteW-1:0]     in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OutTdataW-1:0] out_tdata,
  output int                   mismatches,
  output int                   values_due
);

  width_mode_t       width_sel;
  logic [ValueW-1:0] acc_bits;
  logic [PosW-1:0]   shift_pos;
  step_res_t         expected_values[$];

  initial begin
    mismatches = 0;
    values_due = 0;
  end

  // One byte into the decoder state; emit is set when a value or error ends.
  function automatic step_res_t decode_byte(input logic [ByteW-1:0] b);
    step_res_t         r;
    int unsigned       w;
    int unsigned       s;
    logic [ValueW-1:0] keep;
    r.emit   = 1'b0;
    r.value  = '0;
    r.status = ST_OK;
    w    = 8 << int'(width_sel);
    s    = shift_pos;
    keep = (w >= ValueW) ? '1 : ((ValueW'(1) << w) - ValueW'(1));
    // at the top group only bytes below 2^(W-s) fit, continuation included
    if (s >= w || (s + 7 >= w && int'(b) >= (1 << (w - s)))) begin
      r.emit   = 1'b1;
      r.status = ST_OVERFLOW;
      acc_bits  = '0;
      shift_pos = '0;
      return r;
    end
    acc_bits = acc_bits | (ValueW'(b & PAYLOAD_MASK) << s);
    if ((b & CONT_FLAG) != 0) begin
      shift_pos = shift_pos + GROUP_BITS;
      return r;
    end
    r.emit = 1'b1;
    if (b == '0 && s != 0) begin
      r.status = ST_NONCANON;
    end else begin
      r.value = acc_bits & keep;
    end
    acc_bits  = '0;
    shift_pos = '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    step_res_t         want;
    logic [ValueW-1:0] got_value;
    logic [StatusW-1:0] got_status;
    if (!rst_n) begin
      width_sel = MODE_W64;
      acc_bits  = '0;
      shift_pos = '0;
      expected_values.delete();
    end else begin
      if (cfg_wr_en) begin
        width_sel = width_mode_t'(cfg_wr_data);
      end
      if (in_tvalid && in_tready) begin
        want = decode_byte(in_tdata);
        if (want.emit) begin
          expected_values.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        got_value  = out_tdata[ValueW-1:0];
        got_status = out_tdata[ValueW +: StatusW];
        if (expected_values.size() == 0) begin
          $error("unexpected result: decoded_value %h status %0d", got_value, got_status);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          if (got_value !== want.value) begin
            $error("decoded_value: expected %h, actual %h", want.value, got_value);
            mismatches++;
          end
          if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            mismatches++;
          end
        end
      end
    end
    values_due = expected_values.size();
  end

endmodule

// ===== verif/varint_decoder_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// varint_decoder_tb
// Drives encoded byte streams into the varint decoder at all four widths,
// with random gaps and output stalls, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module varint_decoder_tb;
  import vdec_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 250;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [ModeW-1:0]     cfg_wr_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [ByteW-1:0]     in_tdata;     // [7:0] data_byte
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OutTdataW-1:0] out_tdata;    // [63:0] decoded_value, [65:64] status

  int          mismatches;
  int          values_due;
  int          cycle_count;
  int          bytes_sent;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          long_hold_req;
  width_mode_t cur_mode;

  varint_decoder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  varint_decoder_checker CHK (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .values_due  (values_due)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: ready most of the time, random stall bursts while enabled, and
  // one long hold-off so the output register fills and the input backs up.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte and hold it until accepted; insert a random gap first
  // when sender idling is enabled. Valid stays high into the next byte.
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid, wait for every predicted result, then let the pipe drain so
  // a trailing continuation byte has reached the accumulator.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (values_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input width_mode_t m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_mode     = m;
  endtask

  // Send one encoding with random payload. Lengths run up to one group past
  // the width; the final byte is often zero, or small enough to fit the top
  // group, so that ok, overflow and non-canonical endings all show up.
  task automatic send_random_varint();
    int unsigned      w;
    int unsigned      max_len;
    int unsigned      len;
    int unsigned      s;
    logic [ByteW-1:0] b;
    w       = 8 << int'(cur_mode);
    max_len = (w + 6) / 7;
    case ($urandom_range(0, 9))
      0:       len = max_len + 1;
      1, 2, 3: len = max_len;
      default: len = $urandom_range(1, max_len);
    endcase
    for (int k = 0; k < int'(len) - 1; k++) begin
      send_byte(CONT_FLAG | ByteW'($urandom_range(0, 127)));
    end
    s = 7 * (len - 1);
    case ($urandom_range(0, 9))
      0: b = '0;
      1, 2, 3, 4: begin
        if (s < w && s + 7 >= w) begin
          b = ByteW'($urandom_range(0, (1 << (w - s)) - 1));
        end else begin
          b = ByteW'($urandom_range(0, 127));
        end
      end
      default: b = ByteW'($urandom_range(0, 127));
    endcase
    send_byte(b);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cycle_count   = 0;
    bytes_sent    = 0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    long_hold_req = 1'b0;
    cur_mode      = MODE_W64;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, 64-bit width after reset: zero, largest single byte,
    // non-canonical zero final byte, and the largest 64-bit value.
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'h00);
    repeat (9) send_byte(8'hff);
    send_byte(8'h01);

    // 8-bit width: largest value fits, next group too large.
    settle();
    write_mode(MODE_W8);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h02);

    // Shrink the width while a value is open: the open position is already
    // past the new width, so the next byte overflows and restarts.
    settle();
    write_mode(MODE_W16);
    send_byte(8'h80);
    send_byte(8'h80);
    settle();
    write_mode(MODE_W8);
    send_byte(8'h01);

    // Random part: one width per phase, mostly well-formed encodings with
    // random content, the rest raw noise bytes.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       write_mode(MODE_W8);
        1:       write_mode(MODE_W64);
        2:       write_mode(MODE_W16);
        3:       write_mode(MODE_W32);
        default: write_mode(width_mode_t'($urandom_range(0, 3)));
      endcase
      // idle in bursts on most phases, none in the closing phase
      tx_idle_on = (phase != PHASES - 1) && (phase % 3 != 2);
      rx_idle_on = (phase != PHASES - 1) && (phase % 3 != 1);
      if (phase == 1) begin
        long_hold_req = 1'b1;
      end
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        if ($urandom_range(0, 9) < 2) begin
          send_byte(ByteW'($urandom_range(0, 255)));
        end else begin
          send_random_varint();
        end
      end
    end

    settle();
    if (mismatches == 0 && values_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
